FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the activation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define PLA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication, checked outside reset.
`define PLA_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

FILE: rtl/pla_pkg.sv
// Package: word types, command codes and helpers of the activation block.
`default_nettype none

package pla_pkg;

    typedef enum logic [1:0] {
        KIND_SLOPE  = 2'd0,
        KIND_SCALE  = 2'd1,
        KIND_BUILD  = 2'd2,
        KIND_SAMPLE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         channel;
        logic [3:0]         slope_index;
        logic signed [31:0] value;
        logic [30:0]        reciprocal_scale;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [3:0]         segment;
        logic               saturated;
    } t_out_word;

    // Decoded command held in the queue between front and back.
    typedef struct packed {
        t_kind              kind;
        logic [3:0]         channel;
        logic               slope_ok;
        logic [3:0]         slope_index;
        logic signed [31:0] value;
        logic [30:0]        reciprocal_scale;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic out_load;
    } t_back_stat;

    localparam logic signed [63:0] LIM48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] LIM48_MIN = -64'sh0000_8000_0000_0000;
    localparam logic signed [63:0] LIM32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] LIM32_MIN = -64'sh0000_0000_8000_0000;

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > LIM48_MAX) begin
            r = LIM48_MAX[47:0];
        end else if (v < LIM48_MIN) begin
            r = LIM48_MIN[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sext48(input logic signed [47:0] v);
        return {{16{v[47]}}, v};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pla_front.sv
// Front end: accepts input words and decodes them into queue commands.
`default_nettype none

module pla_front #(
    parameter int CHANNELS = 16,
    parameter int SEGMENTS = 16
) (
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  pla_pkg::t_in_word i_in_word,
    input  pla_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output pla_pkg::t_cmd     o_cmd
);
    import pla_pkg::*;

    // channel modulo CHANNELS for every 4-bit code
    logic [3:0] ch_tbl [16];

    for (genvar g = 0; g < 16; g++) begin : g_ch_mod
        assign ch_tbl[g] = 4'(g % CHANNELS);
    end

    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    always_comb begin
        o_cmd.kind             = i_in_word.kind;
        o_cmd.channel          = ch_tbl[i_in_word.channel];
        o_cmd.slope_ok         = (32'(i_in_word.slope_index) < SEGMENTS);
        o_cmd.slope_index      = i_in_word.slope_index;
        o_cmd.value            = i_in_word.value;
        o_cmd.reciprocal_scale = i_in_word.reciprocal_scale;
    end

endmodule

`default_nettype wire

FILE: rtl/pla_fifo.sv
// Command queue between the front end and the execution back end.
`default_nettype none

module pla_fifo #(
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  pla_pkg::t_cmd    i_word,
    input  wire              i_pop,
    output pla_pkg::t_cmd    o_word,
    output pla_pkg::t_q_stat o_stat
);
    import pla_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && (r_count != CNT_W'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    assign o_word       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pla_back.sv
// Back end: table memories, shared multiplier, sample and intercept build sequencer.
`default_nettype none

module pla_back #(
    parameter int CHANNELS  = 16,
    parameter int SEGMENTS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pla_pkg::t_cmd       i_q_word,
    input  pla_pkg::t_q_stat    i_q_stat,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output pla_pkg::t_out_word  o_out_word,
    output pla_pkg::t_back_stat o_stat
);
    import pla_pkg::*;

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SEG_W    = $clog2(SEGMENTS);
    localparam int ADDR_W   = CH_W + SEG_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int CH_DEPTH = 1 << CH_W;
    localparam int HALF     = SEGMENTS / 2;

    localparam logic signed [63:0] HALF_S   = 64'(HALF);
    localparam logic signed [63:0] SEG_LAST = 64'(SEGMENTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S_MUL1,
        ST_S_SEG,
        ST_S_MUL2,
        ST_S_SUM,
        ST_B_MULP,
        ST_B_MULQ,
        ST_B_SCL,
        ST_B_WRP,
        ST_B_WRN
    } t_state;

    // table memories
    logic signed [31:0] r_slope_mem [DEPTH];
    logic signed [47:0] r_icpt_mem  [DEPTH];
    logic [62:0]        r_param_mem [CH_DEPTH];   // {scale, reciprocal}
    logic signed [31:0] r_slope_rd;
    logic signed [47:0] r_icpt_rd;
    logic [62:0]        r_param_rd;

    // sequencer and datapath registers
    t_state             r_state;
    t_cmd               r_cmd;
    logic [7:0]         r_i;
    logic [7:0]         r_step;
    logic signed [47:0] r_sum_pos;
    logic signed [47:0] r_sum_neg;
    logic signed [63:0] r_prod;
    logic signed [47:0] r_p;
    logic signed [47:0] r_q;
    logic signed [56:0] r_pi;
    logic signed [56:0] r_qi;
    logic signed [47:0] r_icpt;
    logic [SEG_W-1:0]   r_seg;
    logic               r_out_valid;
    t_out_word          r_out_word;

    // memory ports
    logic               slope_we;
    logic [ADDR_W-1:0]  slope_waddr;
    logic [ADDR_W-1:0]  slope_raddr;
    logic               icpt_we;
    logic [ADDR_W-1:0]  icpt_waddr;
    logic signed [47:0] icpt_wdata;
    logic [ADDR_W-1:0]  icpt_raddr;
    logic               param_we;
    logic [CH_W-1:0]    param_addr;

    // combinational datapath
    logic [CH_W-1:0]    q_ch;
    logic [CH_W-1:0]    c_ch;
    logic [7:0]         i_eff;
    logic [7:0]         ip1;
    logic signed [31:0] prm_scale;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [63:0] fl_f;
    logic signed [63:0] xq;
    logic signed [63:0] n_full;
    logic [SEG_W-1:0]   n_seg;
    logic signed [63:0] y_full;
    logic signed [31:0] y_sat;
    logic               y_clip;
    logic               out_free;
    logic               out_load;
    logic               pop;

    assign q_ch      = CH_W'(i_q_word.channel);
    assign c_ch      = CH_W'(r_cmd.channel);
    assign i_eff     = (r_step >= 8'(HALF)) ? 8'd0 : r_step;
    assign ip1       = r_i + 8'd1;
    assign prm_scale = r_param_rd[62:31];

    // one shared 32x32 signed multiplier
    always_comb begin
        unique case (r_state)
            ST_S_MUL1: begin
                mul_a = r_cmd.value;
                mul_b = $signed({1'b0, r_param_rd[30:0]});
            end
            ST_S_MUL2: begin
                mul_a = r_cmd.value;
                mul_b = r_slope_rd;
            end
            default: begin
                mul_a = r_slope_rd;
                mul_b = prm_scale;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign fl_f  = r_prod >>> FRAC_BITS;

    // segment pick: floor(sample * recip / 2^(2*FRAC_BITS)) + half, clamped
    assign xq     = r_prod >>> (2 * FRAC_BITS);
    assign n_full = xq + HALF_S;
    always_comb begin
        if (n_full < 64'sd0) begin
            n_seg = '0;
        end else if (n_full > SEG_LAST) begin
            n_seg = SEG_W'(SEGMENTS - 1);
        end else begin
            n_seg = n_full[SEG_W-1:0];
        end
    end

    assign y_full = fl_f + sext48(r_icpt);
    always_comb begin
        if (y_full > LIM32_MAX) begin
            y_sat  = LIM32_MAX[31:0];
            y_clip = 1'b1;
        end else if (y_full < LIM32_MIN) begin
            y_sat  = LIM32_MIN[31:0];
            y_clip = 1'b1;
        end else begin
            y_sat  = y_full[31:0];
            y_clip = 1'b0;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign out_load = (r_state == ST_S_SUM) && out_free;

    // memory port control
    always_comb begin
        slope_we    = 1'b0;
        slope_waddr = {q_ch, SEG_W'(i_q_word.slope_index)};
        slope_raddr = {c_ch, n_seg};
        icpt_we     = 1'b0;
        icpt_waddr  = {c_ch, SEG_W'(HALF) + SEG_W'(r_i)};
        icpt_wdata  = sat48(sext48(r_sum_pos) - 64'(r_pi));
        icpt_raddr  = {c_ch, n_seg};
        param_we    = 1'b0;
        param_addr  = c_ch;
        unique case (r_state)
            ST_IDLE: begin
                param_addr  = q_ch;
                slope_raddr = {q_ch, SEG_W'(HALF) + SEG_W'(i_eff)};
                if (pop) begin
                    slope_we = (i_q_word.kind == KIND_SLOPE) && i_q_word.slope_ok;
                    param_we = (i_q_word.kind == KIND_SCALE);
                end
            end
            ST_B_MULP: begin
                slope_raddr = {c_ch, SEG_W'(HALF - 1) - SEG_W'(r_i)};
            end
            ST_B_WRP: begin
                icpt_we = 1'b1;
            end
            ST_B_WRN: begin
                icpt_we    = 1'b1;
                icpt_waddr = {c_ch, SEG_W'(HALF - 1) - SEG_W'(r_i)};
                icpt_wdata = sat48(sext48(r_sum_neg) + 64'(r_qi));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slope_we) begin
            r_slope_mem[slope_waddr] <= i_q_word.value;
        end
        r_slope_rd <= r_slope_mem[slope_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (icpt_we) begin
            r_icpt_mem[icpt_waddr] <= icpt_wdata;
        end
        r_icpt_rd <= r_icpt_mem[icpt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (param_we) begin
            r_param_mem[param_addr] <= {i_q_word.value, i_q_word.reciprocal_scale};
        end
        r_param_rd <= r_param_mem[param_addr];
    end

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_sum_pos   <= '0;
            r_sum_neg   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (pop) begin
                        r_cmd <= i_q_word;
                        r_i   <= i_eff;
                        if (i_q_word.kind == KIND_BUILD) begin
                            r_state <= ST_B_MULP;
                            if (i_eff == 8'd0) begin
                                r_sum_pos <= '0;
                                r_sum_neg <= '0;
                            end
                        end else if (i_q_word.kind == KIND_SAMPLE) begin
                            r_state <= ST_S_MUL1;
                        end
                    end
                end
                ST_S_MUL1: begin
                    r_prod  <= mul_p;
                    r_state <= ST_S_SEG;
                end
                ST_S_SEG: begin
                    r_seg   <= n_seg;
                    r_state <= ST_S_MUL2;
                end
                ST_S_MUL2: begin
                    r_prod  <= mul_p;
                    r_icpt  <= r_icpt_rd;
                    r_state <= ST_S_SUM;
                end
                ST_S_SUM: begin
                    if (out_free) begin
                        r_out_word.result_value <= y_sat;
                        r_out_word.segment      <= 4'(r_seg);
                        r_out_word.saturated    <= y_clip;
                        r_state                 <= ST_IDLE;
                    end
                end
                ST_B_MULP: begin
                    r_prod  <= mul_p;
                    r_state <= ST_B_MULQ;
                end
                ST_B_MULQ: begin
                    r_p     <= sat48(fl_f);
                    r_prod  <= mul_p;
                    r_state <= ST_B_SCL;
                end
                ST_B_SCL: begin
                    r_q     <= sat48(fl_f);
                    r_pi    <= r_p * $signed({1'b0, r_i});
                    r_state <= ST_B_WRP;
                end
                ST_B_WRP: begin
                    r_sum_pos <= sat48(sext48(r_sum_pos) + sext48(r_p));
                    r_sum_neg <= sat48(sext48(r_sum_neg) - sext48(r_q));
                    r_qi      <= r_q * $signed({1'b0, ip1});
                    r_state   <= ST_B_WRN;
                end
                ST_B_WRN: begin
                    r_step  <= (ip1 >= 8'(HALF)) ? 8'd0 : ip1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_q_pop         = pop;
    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out_word;
    assign o_stat.busy     = (r_state != ST_IDLE);
    assign o_stat.out_load = out_load;

endmodule

`default_nettype wire

FILE: rtl/piecewise_linear_activation.sv
// Top level of the per-channel learned piecewise-linear activation block.
//
// Input channel: i_in_valid / o_in_stall carry one t_in_word per accepted word
//   (valid high, stall low at a rising edge). Kinds: load one slope, load a
//   channel's scale and reciprocal scale, one intercept build step, sample.
// Output channel: o_out_valid / i_out_stall carry one t_out_word for each
//   sample word and nothing for the other kinds. Results keep input order.
// Sequencing: the back end runs one command at a time over one multiplier.
//   A slope or scale load is written from the idle state, a sample steps
//   through S_MUL1, S_SEG, S_MUL2 and S_SUM, a build step through B_MULP,
//   B_MULQ, B_SCL, B_WRP and B_WRN; the 4-entry command queue absorbs bursts
//   meanwhile. A sample's result enters the output register from S_SUM.
// Stall: a finished result waits in the output register; the back end keeps
//   running loads and builds until the next sample waits in S_SUM, and the
//   front keeps accepting until the queue fills, when o_in_stall rises.
// Reset: synchronous, active low. Clears queue, sequencer, build step and
//   running sums. Table memories are not cleared and hold garbage until
//   software loads them.
`default_nettype none
`include "assert_macros.svh"

module piecewise_linear_activation #(
    parameter int CHANNELS  = 16,
    parameter int SEGMENTS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  pla_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output pla_pkg::t_out_word o_out_word
);
    import pla_pkg::*;

    localparam int Q_DEPTH = 4;

    t_cmd       fr_cmd;
    logic       fr_push;
    t_cmd       q_word;
    t_q_stat    q_stat;
    logic       bk_pop;
    t_back_stat bk_stat;

    // front: handshake and decode (channel wrap, slope slot check)
    pla_front #(
        .CHANNELS (CHANNELS),
        .SEGMENTS (SEGMENTS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_stat   (q_stat),
        .o_push     (fr_push),
        .o_cmd      (fr_cmd)
    );

    // decoupling queue
    pla_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_word  (fr_cmd),
        .i_pop   (bk_pop),
        .o_word  (q_word),
        .o_stat  (q_stat)
    );

    // back: tables, multiplier, sequencer, output register
    pla_back #(
        .CHANNELS  (CHANNELS),
        .SEGMENTS  (SEGMENTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_word    (q_word),
        .i_q_stat    (q_stat),
        .o_q_pop     (bk_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .o_stat      (bk_stat)
    );

    // a command is only taken from a non-empty queue
    `PLA_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, bk_pop, !q_stat.empty, "pop from empty queue")

    // a new output word appears only after the sequencer loaded one
    `PLA_ASSERT_IMPL(a_out_from_load, i_clk, i_rst_n, $rose(o_out_valid), $past(bk_stat.out_load), "output valid without load")

    // clamped segment stays within the table
    `PLA_ASSERT_IMPL(a_seg_range, i_clk, i_rst_n, o_out_valid, (32'(o_out_word.segment) <= SEGMENTS - 1), "segment out of range")

    // a clipped result sits on one of the 32-bit rails
    `PLA_ASSERT_IMPL(a_sat_rail, i_clk, i_rst_n, o_out_valid && o_out_word.saturated, (o_out_word.result_value == 32'sh7FFF_FFFF) || (o_out_word.result_value == -32'sh8000_0000), "saturation flag off rail")

endmodule

`default_nettype wire

FILE: dv/piecewise_linear_activation_test.sv
// Self-checking testbench for the per-channel piecewise-linear activation block.
`default_nettype none

module piecewise_linear_activation_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pla_pkg::*;

    localparam int CHANNELS  = 16;
    localparam int SEGMENTS  = 16;
    localparam int FRAC_BITS = 16;
    localparam int HALF_SEGS = SEGMENTS / 2;

    // Run bounds. The cycle limit sits far above the slowest legal run
    // (sample or build in the back end plus sender gaps and output stalls).
    localparam int RANDOM_WORDS = 1450;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int TAIL_CYCLES  = 64;

    localparam longint HI48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LO48 = -HI48 - 1;
    localparam longint HI32 = 64'sh0000_0000_7FFF_FFFF;
    localparam longint LO32 = -HI32 - 1;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    piecewise_linear_activation #(
        .CHANNELS  (CHANNELS),
        .SEGMENTS  (SEGMENTS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block's tables.
    // The *_set flags track which entries hold a loaded value, so that no
    // word is ever sent that would read an entry still holding garbage.
    // ------------------------------------------------------------------
    logic signed [31:0] slope_tab [CHANNELS][SEGMENTS];
    logic signed [31:0] scale_tab [CHANNELS];
    logic [30:0]        recip_tab [CHANNELS];
    longint             icpt_tab  [CHANNELS][SEGMENTS];
    bit                 slope_set [CHANNELS][SEGMENTS];
    bit                 scale_set [CHANNELS];
    bit                 icpt_set  [CHANNELS][SEGMENTS];

    // Intercept walk: one step counter and two running sums for all channels.
    int     walk_step = 0;
    longint run_pos   = 0;
    longint run_neg   = 0;

    t_out_word pending_activations [$];

    int words_sent    = 0;
    int n_errors      = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    function automatic longint clamp48(input longint v);
        if (v > HI48) return HI48;
        if (v < LO48) return LO48;
        return v;
    endfunction

    // Segment = floor(x * recip / 2^(2F)) + K, clamped to the table.
    function automatic int pick_segment(input int ch, input logic signed [31:0] x);
        longint n;
        n = ((longint'(x) * longint'(recip_tab[ch])) >>> (2 * FRAC_BITS)) + HALF_SEGS;
        if (n < 0) n = 0;
        if (n > SEGMENTS - 1) n = SEGMENTS - 1;
        return int'(n);
    endfunction

    // One walk step: fills intercept K+i going up and K-1-i going down.
    // Step 0 restarts both sums, whatever channel the step belongs to.
    function automatic void step_intercepts(input int ch);
        int     i;
        longint sc, p, q;
        i = walk_step;
        if (i == 0) begin
            run_pos = 0;
            run_neg = 0;
        end
        sc = longint'(scale_tab[ch]);
        p = clamp48((longint'(slope_tab[ch][HALF_SEGS + i]) * sc) >>> FRAC_BITS);
        q = clamp48((longint'(slope_tab[ch][HALF_SEGS - 1 - i]) * sc) >>> FRAC_BITS);
        icpt_tab[ch][HALF_SEGS + i] = clamp48(run_pos - p * longint'(i));
        icpt_set[ch][HALF_SEGS + i] = 1'b1;
        run_pos = clamp48(run_pos + p);
        run_neg = clamp48(run_neg - q);
        icpt_tab[ch][HALF_SEGS - 1 - i] = clamp48(run_neg + q * longint'(i + 1));
        icpt_set[ch][HALF_SEGS - 1 - i] = 1'b1;
        walk_step = (i + 1 >= HALF_SEGS) ? 0 : i + 1;
    endfunction

    // True when the word only reads table entries that were loaded.
    function automatic bit reads_known(input t_in_word w);
        int ch, n;
        ch = int'(w.channel) % CHANNELS;
        case (w.kind)
            KIND_SAMPLE: begin
                if (!scale_set[ch]) return 1'b0;
                n = pick_segment(ch, w.value);
                return slope_set[ch][n] && icpt_set[ch][n];
            end
            KIND_BUILD: begin
                return scale_set[ch] && slope_set[ch][HALF_SEGS + walk_step]
                    && slope_set[ch][HALF_SEGS - 1 - walk_step];
            end
            default: return 1'b1;
        endcase
    endfunction

    // Update the shadow tables with an accepted word; samples queue
    // their expected activation.
    function automatic void apply_word(input t_in_word w);
        int        ch, n;
        longint    y;
        t_out_word r;
        ch = int'(w.channel) % CHANNELS;
        case (w.kind)
            KIND_SLOPE: begin
                if (w.slope_index < SEGMENTS) begin
                    slope_tab[ch][w.slope_index] = w.value;
                    slope_set[ch][w.slope_index] = 1'b1;
                end
            end
            KIND_SCALE: begin
                scale_tab[ch] = w.value;
                recip_tab[ch] = w.reciprocal_scale;
                scale_set[ch] = 1'b1;
            end
            KIND_BUILD: step_intercepts(ch);
            default: begin
                n = pick_segment(ch, w.value);
                y = ((longint'($signed(w.value)) * longint'(slope_tab[ch][n])) >>> FRAC_BITS)
                    + icpt_tab[ch][n];
                r.saturated = 1'b0;
                if (y > HI32) begin
                    y = HI32;
                    r.saturated = 1'b1;
                end
                if (y < LO32) begin
                    y = LO32;
                    r.saturated = 1'b1;
                end
                r.result_value = y[31:0];
                r.segment      = n[3:0];
                pending_activations.push_back(r);
            end
        endcase
    endfunction

    function automatic t_in_word make_word(input t_kind k, input int ch, input int idx,
                                           input logic [31:0] v, input logic [30:0] r);
        t_in_word w;
        w.kind             = k;
        w.channel          = ch[3:0];
        w.slope_index      = idx[3:0];
        w.value            = v;
        w.reciprocal_scale = r;
        return w;
    endfunction

    // Slopes: mostly within +-4.0, some full range, some at the rails.
    function automatic logic [31:0] slope_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return 32'($signed($urandom_range(524288)) - 262144);
        if (pick < 90) return $urandom;
        return (pick < 95) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    // Samples: mostly spread over about ten segment widths either side of
    // the middle, so every segment and both clamps get hit.
    function automatic logic [31:0] sample_value(input int ch);
        int     pick;
        longint seg_w, lim, u;
        pick = $urandom_range(99);
        if (!scale_set[ch] || pick < 25) return $urandom;
        if (pick < 37) begin
            case ($urandom_range(4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        seg_w = 64'sd4294967296 / longint'(recip_tab[ch]);
        lim = seg_w * 10;
        if (lim > HI32) lim = HI32;
        if (lim < 1) lim = 1;
        u = longint'({$urandom, $urandom} >> 1);
        return 32'((u % (2 * lim + 1)) - lim);
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional idle gap with valid low, then hold valid and the
    // word until an edge with stall low takes it.
    // ------------------------------------------------------------------
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_word(w);
        words_sent++;
    endtask

    // Scale word: usually a sane scale of 0.25..4.0 with matching
    // reciprocal, sometimes arbitrary bits in both fields.
    task automatic send_scale(input int ch);
        logic [31:0] s;
        logic [30:0] r;
        if ($urandom_range(3) == 0) begin
            s = $urandom;
            r = 31'($urandom_range(32'h7FFF_FFFF, 1));
        end else begin
            s = $urandom_range(1 << 18, 1 << 14);
            r = 31'(64'd4294967296 / s);
        end
        send_word(make_word(KIND_SCALE, ch, $urandom_range(15), s, r));
    endtask

    // Full table setup: all slopes in shuffled order, scale, then a clean
    // walk (any walk left half done by other channels is finished first).
    task automatic load_channel(input int ch);
        int order [SEGMENTS];
        int j, tmp;
        for (int i = 0; i < SEGMENTS; i++) order[i] = i;
        for (int i = SEGMENTS - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < SEGMENTS; i++) begin
            send_word(make_word(KIND_SLOPE, ch, order[i], slope_value(), 31'($urandom)));
        end
        send_scale(ch);
        while (walk_step != 0) begin
            send_word(make_word(KIND_BUILD, ch, $urandom_range(15), $urandom, 31'($urandom)));
        end
        repeat (HALF_SEGS) begin
            send_word(make_word(KIND_BUILD, ch, $urandom_range(15), $urandom, 31'($urandom)));
        end
    endtask

    function automatic int ready_channel();
        int  found [$];
        bit  ok;
        for (int c = 0; c < CHANNELS; c++) begin
            ok = scale_set[c];
            for (int s = 0; s < SEGMENTS; s++) ok = ok && slope_set[c][s] && icpt_set[c][s];
            if (ok) found.push_back(c);
        end
        if (found.size() == 0) return -1;
        return found[$urandom_range(found.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Rail, zero and unit slopes with the largest scale and reciprocal: products
    // overflow 48 bits in the walk, samples clamp at both ends and saturate.
    task automatic test_extreme_fields();
        logic [31:0] rails [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1};
        logic [31:0] probes [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1};
        for (int i = 0; i < SEGMENTS; i++) begin
            send_word(make_word(KIND_SLOPE, 15, i, rails[i % 4], 31'h7FFF_FFFF));
        end
        send_word(make_word(KIND_SCALE, 15, 15, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        repeat (HALF_SEGS) send_word(make_word(KIND_BUILD, 15, 0, 32'h0, 31'h0));
        foreach (probes[i]) send_word(make_word(KIND_SAMPLE, 15, 0, probes[i], 31'h0));
    endtask

    // Most negative scale with the smallest reciprocal: every sample lands
    // in one of the two middle segments. The walk is then left half done
    // so the random part starts mid-walk.
    task automatic test_scale_extremes();
        send_word(make_word(KIND_SCALE, 15, 0, 32'h8000_0000, 31'h1));
        repeat (HALF_SEGS) send_word(make_word(KIND_BUILD, 15, 15, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
        send_word(make_word(KIND_SAMPLE, 15, 15, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_word(make_word(KIND_SAMPLE, 15, 15, 32'h8000_0000, 31'h7FFF_FFFF));
        repeat (3) send_word(make_word(KIND_BUILD, 15, 0, 32'h0, 31'h0));
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly samples on loaded channels, with full table
    // setups, stray slope and scale reloads, whole walks and single walk
    // steps that interleave channels into one shared walk.
    // ------------------------------------------------------------------
    task automatic run_random_traffic(input int idle_pct, input int stall_level,
                                      input int n_words);
        int       stop_at, ch, pick, steps;
        t_in_word w;
        send_idle_pct = idle_pct;
        stall_pct     = stall_level;
        stop_at       = words_sent + n_words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            ch   = $urandom_range(CHANNELS - 1);
            if (pick < 50) begin
                w = make_word(KIND_SAMPLE, ch, $urandom_range(15), sample_value(ch),
                              31'($urandom));
                if (!reads_known(w)) begin
                    ch = ready_channel();
                    if (ch < 0) begin
                        load_channel($urandom_range(CHANNELS - 1));
                        continue;
                    end
                    w = make_word(KIND_SAMPLE, ch, $urandom_range(15), sample_value(ch),
                                  31'($urandom));
                end
                send_word(w);
            end else if (pick < 57) begin
                load_channel(ch);
            end else if (pick < 67) begin
                send_word(make_word(KIND_SLOPE, ch, $urandom_range(15), slope_value(),
                                    31'($urandom)));
            end else if (pick < 73) begin
                send_scale(ch);
            end else if (pick < 92) begin
                steps = (pick < 82) ? HALF_SEGS : 1;
                repeat (steps) begin
                    w = make_word(KIND_BUILD, ch, $urandom_range(15), $urandom,
                                  31'($urandom));
                    if (reads_known(w)) send_word(w);
                end
            end else begin
                // back-to-back sample stream on one channel
                ch = ready_channel();
                if (ch >= 0) begin
                    repeat ($urandom_range(12, 4)) begin
                        send_word(make_word(KIND_SAMPLE, ch, $urandom_range(15),
                                            sample_value(ch), 31'($urandom)));
                    end
                end
            end
        end
    endtask

    task automatic test_full_rate();
        run_random_traffic(0, 0, RANDOM_WORDS / 4);
    endtask

    task automatic test_sender_gaps();
        run_random_traffic(61, 0, RANDOM_WORDS / 4);
    endtask

    task automatic test_receiver_stalls();
        run_random_traffic(0, 61, RANDOM_WORDS / 4);
    endtask

    task automatic test_both_sides_idle();
        run_random_traffic(18, 18, RANDOM_WORDS / 4);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, and a check of every accepted result word
    // against the oldest pending activation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_activations.size() == 0) begin
                $error("unexpected result word %h", o_out_word);
                n_errors++;
            end else begin
                want = pending_activations.pop_front();
                if (o_out_word.result_value !== want.result_value) begin
                    $error("result_value: expected %0d, got %0d",
                           want.result_value, o_out_word.result_value);
                    n_errors++;
                end
                if (o_out_word.segment !== want.segment) begin
                    $error("segment: expected %0d, got %0d", want.segment, o_out_word.segment);
                    n_errors++;
                end
                if (o_out_word.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, o_out_word.saturated);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on a hung handshake or a lost result.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_fields();
        test_scale_extremes();
        test_full_rate();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_sides_idle();

        // drain: stop sending, let the output run free, then allow for
        // build steps still working in the back end
        i_in_valid    <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        while (pending_activations.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_activations.size() != 0) begin
            $error("%0d activations never arrived", pending_activations.size());
            n_errors++;
        end

        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/pla_pkg.sv
rtl/pla_front.sv
rtl/pla_fifo.sv
rtl/pla_back.sv
rtl/piecewise_linear_activation.sv
dv/piecewise_linear_activation_test.sv
